// File: sv/dbfa_pkg.sv
package dbfa_pkg;

  // default pool sizes in bits
  localparam int BLOCK_BITS_DEF = 1024;
  localparam int INODE_BITS_DEF = 256;

  // map layout: bytes of eight bits, eight bytes to one memory row
  localparam int MAP_WORD_BITS = 8;
  localparam int ROW_BYTES     = 8;
  localparam int ROW_BITS      = MAP_WORD_BITS * ROW_BYTES;
  localparam int ROW_SHIFT     = $clog2(ROW_BITS);
  localparam logic [MAP_WORD_BITS-1:0] FULL_BYTE = 8'hFF;

  // register reset values
  localparam int BLOCK_TOTAL_RST = 1024;
  localparam int INODE_TOTAL_RST = 256;

  // field widths
  localparam int NUM_W   = 11;
  localparam int BTOT_W  = 11;
  localparam int ITOT_W  = 9;
  localparam int CFGI_W  = 2;

  // command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // register indexes
  localparam logic [CFGI_W-1:0] REG_BLOCK_TOTAL = 2'd0;
  localparam logic [CFGI_W-1:0] REG_INODE_TOTAL = 2'd1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             pool;
    logic [NUM_W-1:0] item_number;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [NUM_W-1:0] result_number;
    logic             bit_value;
    logic [NUM_W-1:0] free_left;
  } rsp_t;

  // outcome of examining one map row
  typedef struct packed {
    logic       hit;
    logic [2:0] byte_sel;
    logic [2:0] bit_sel;
  } scan_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_OPRD,
    S_OPEV,
    S_FIN
  } state_t;

endpackage

// File: sv/dbfa_map_ram.sv
module dbfa_map_ram
  import dbfa_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = ROW_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/dbfa_row_scan.sv
module dbfa_row_scan
  import dbfa_pkg::*;
(
  input  logic [ROW_BITS-1:0]  row_data,
  input  logic [ROW_BYTES-1:0] byte_en,
  output scan_t                scan
);

  logic [ROW_BYTES-1:0]     byte_open;
  logic [2:0]               byte_sel;
  logic [MAP_WORD_BITS-1:0] byte_val;
  logic [2:0]               bit_sel;

  // bytes in range that still have a clear bit
  always_comb begin
    for (int j = 0; j < ROW_BYTES; j++) begin
      byte_open[j] = byte_en[j] && (row_data[j*MAP_WORD_BITS +: MAP_WORD_BITS] != FULL_BYTE);
    end
  end

  // first open byte
  always_comb begin
    byte_sel = 3'd0;
    for (int j = ROW_BYTES - 1; j >= 0; j--) begin
      if (byte_open[j]) begin
        byte_sel = 3'(j);
      end
    end
  end

  // lowest clear bit of that byte
  always_comb begin
    byte_val = row_data[byte_sel*MAP_WORD_BITS +: MAP_WORD_BITS];
    bit_sel  = 3'd0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (!byte_val[b]) begin
        bit_sel = 3'(b);
      end
    end
  end

  assign scan.hit      = |byte_open;
  assign scan.byte_sel = byte_sel;
  assign scan.bit_sel  = bit_sel;

endmodule

// File: sv/dual_bitmap_first_fit_allocator_core.sv
// Two first-fit bitmap allocators (pool 0 inodes, pool 1 blocks) behind one
// command channel. Each map sits in its own memory of 64-bit rows, and one
// shared row scanner examines a row per cycle to find the lowest clear bit.
// After reset both maps are swept to zero, one row a cycle, over
// max(ceil(BLOCK_BITS/64), ceil(INODE_BITS/64)) rows (16 at the defaults);
// commands are held off meanwhile, config writes are taken. Free, mark and
// read pass through check, row read, update and result; an item number out
// of range goes from check straight to result. Allocate scans rows from row
// 0 up to the one holding the free bit, at most ceil(total/64) rows. A scan
// that finds no clear bit returns no-space. The scan rate is set by the
// single memory port, one row per cycle. Allocate with a zero free count
// returns no-space without a scan. A new command is taken in the cycle
// after the previous result is registered, even if that result has not
// been taken yet.
module dual_bitmap_first_fit_allocator_core
  import dbfa_pkg::*;
#(
  parameter int BLOCK_BITS = BLOCK_BITS_DEF,
  parameter int INODE_BITS = INODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_t              cmd_word,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp_word,
  input  logic              cfg_write,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [BTOT_W-1:0] cfg_data
);

  localparam int B_ROWS   = (BLOCK_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int I_ROWS   = (INODE_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int B_AW     = (B_ROWS > 1) ? $clog2(B_ROWS) : 1;
  localparam int I_AW     = (I_ROWS > 1) ? $clog2(I_ROWS) : 1;
  localparam int MAX_ROWS = (B_ROWS > I_ROWS) ? B_ROWS : I_ROWS;
  localparam int CW       = $clog2(MAX_ROWS + 1);

  localparam int B_RST_I = ((BLOCK_TOTAL_RST > BLOCK_BITS) ? BLOCK_BITS : BLOCK_TOTAL_RST)
                           / 8 * 8;
  localparam int I_RST_I = ((INODE_TOTAL_RST > INODE_BITS) ? INODE_BITS : INODE_TOTAL_RST)
                           / 8 * 8;
  localparam logic [BTOT_W-1:0] FREE_B_RST = BTOT_W'(B_RST_I);
  localparam logic [ITOT_W-1:0] FREE_I_RST = ITOT_W'(I_RST_I);

  state_t state, state_next;

  logic [BTOT_W-1:0] block_total, free_blocks;
  logic [ITOT_W-1:0] inode_total, free_inodes;
  logic [BTOT_W-1:0] eff_block_raw, eff_block;
  logic [ITOT_W-1:0] eff_inode_raw, eff_inode;

  logic [1:0]       cmd_r;
  logic             pool_r;
  logic [NUM_W-1:0] num_r;

  logic [1:0]       res_status;
  logic [NUM_W-1:0] res_num;
  logic             res_bit;

  logic [CW-1:0]       clr_cnt;
  logic [CW-1:0]       rd_row;
  logic [CW-1:0]       ev_row;
  logic [CW-1:0]       row_addr;
  logic                pend;
  logic [ROW_BITS-1:0] wr_data;

  logic [CW-1:0]       ram_addr;
  logic [ROW_BITS-1:0] ram_wdata;
  logic                we_b, we_i;
  logic [ROW_BITS-1:0] rd_b, rd_i, rd_data;

  logic [BTOT_W-1:0]    cur_total, cur_free;
  logic [NUM_W-1:0]     num_m1;
  logic [15:0]          nbytes16, nrows16, op_row16;
  logic [ROW_BYTES-1:0] byte_en;
  logic                 last_row, rd_more, clr_last;
  scan_t                scan;
  logic                 ev_hit, ev_miss;
  logic [NUM_W-1:0]     alloc_num;
  logic [5:0]           op_pos;
  logic                 op_bit;
  logic [ROW_BITS-1:0]  op_wdata;
  logic                 range_bad, no_free, rsp_free;
  logic                 dec, inc;

  // effective totals: capped at map size, rounded down to whole bytes
  always_comb begin
    if (32'(block_total) > BLOCK_BITS) begin
      eff_block_raw = BTOT_W'(BLOCK_BITS);
    end else begin
      eff_block_raw = block_total;
    end
    if (32'(inode_total) > INODE_BITS) begin
      eff_inode_raw = ITOT_W'(INODE_BITS);
    end else begin
      eff_inode_raw = inode_total;
    end
    eff_block = eff_block_raw & ~BTOT_W'(7);
    eff_inode = eff_inode_raw & ~ITOT_W'(7);
  end

  // chosen pool view
  assign cur_total = pool_r ? eff_block : {2'b00, eff_inode};
  assign cur_free  = pool_r ? free_blocks : {2'b00, free_inodes};
  assign rd_data   = pool_r ? rd_b : rd_i;
  assign num_m1    = num_r - NUM_W'(1);
  assign range_bad = (num_r == '0) || (num_r > cur_total);
  assign no_free   = (cur_free == '0);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign clr_last  = (32'(clr_cnt) == MAX_ROWS - 1);

  // scan bookkeeping
  assign nbytes16 = {8'd0, cur_total[BTOT_W-1:3]};
  assign nrows16  = (nbytes16 + 16'd7) >> 3;
  assign ev_row   = rd_row - CW'(1);
  assign last_row = ((16'(ev_row) + 16'd1) == nrows16);
  assign rd_more  = (16'(rd_row) < nrows16);

  always_comb begin
    for (int j = 0; j < ROW_BYTES; j++) begin
      byte_en[j] = ((16'(ev_row) << 3) + 16'(j)) < nbytes16;
    end
  end

  dbfa_row_scan u_scan (
    .row_data (rd_data),
    .byte_en  (byte_en),
    .scan     (scan)
  );

  assign ev_hit    = pend && scan.hit;
  assign ev_miss   = pend && !scan.hit && last_row;
  assign alloc_num = NUM_W'((16'(ev_row) << ROW_SHIFT) +
                            16'({scan.byte_sel, scan.bit_sel}) + 16'd1);

  // single-item update
  assign op_row16 = 16'(num_m1 >> ROW_SHIFT);
  assign op_pos   = num_m1[5:0];
  assign op_bit   = rd_data[op_pos];
  always_comb begin
    if (cmd_r == CMD_FREE) begin
      op_wdata = rd_data & ~(ROW_BITS'(1) << op_pos);
    end else begin
      op_wdata = rd_data | (ROW_BITS'(1) << op_pos);
    end
  end

  // free count steps
  assign dec = ((state == S_SCAN) && ev_hit) ||
               ((state == S_OPEV) && (cmd_r == CMD_MARK) && !no_free);
  assign inc = (state == S_OPEV) && (cmd_r == CMD_FREE) && (cur_free < cur_total);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_r == CMD_ALLOC) begin
          state_next = no_free ? S_FIN : S_SCAN;
        end else begin
          state_next = range_bad ? S_FIN : S_OPRD;
        end
      end
      S_SCAN: begin
        if (ev_hit) begin
          state_next = S_WRITE;
        end else if (ev_miss) begin
          state_next = S_FIN;
        end
      end
      S_WRITE: state_next = S_FIN;
      S_OPRD:  state_next = S_OPEV;
      S_OPEV:  state_next = S_FIN;
      S_FIN: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory port and handshake controls
  always_comb begin
    cmd_stall = 1'b1;
    ram_addr  = row_addr;
    ram_wdata = op_wdata;
    we_b      = 1'b0;
    we_i      = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_addr  = clr_cnt;
        ram_wdata = '0;
        we_b      = (32'(clr_cnt) < B_ROWS);
        we_i      = (32'(clr_cnt) < I_ROWS);
      end
      S_IDLE: begin
        cmd_stall = 1'b0;
      end
      S_SCAN: begin
        ram_addr = rd_row;
      end
      S_WRITE: begin
        ram_wdata = wr_data;
        we_b      = pool_r;
        we_i      = !pool_r;
      end
      S_OPEV: begin
        we_b = pool_r && (cmd_r != CMD_READ);
        we_i = !pool_r && (cmd_r != CMD_READ);
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

  dbfa_map_ram #(.DEPTH(B_ROWS), .AW(B_AW), .DW(ROW_BITS)) u_block_ram (
    .clk   (clk),
    .we    (we_b),
    .addr  (ram_addr[B_AW-1:0]),
    .wdata (ram_wdata),
    .rdata (rd_b)
  );

  dbfa_map_ram #(.DEPTH(I_ROWS), .AW(I_AW), .DW(ROW_BITS)) u_inode_ram (
    .clk   (clk),
    .we    (we_i),
    .addr  (ram_addr[I_AW-1:0]),
    .wdata (ram_wdata),
    .rdata (rd_i)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      if (state == S_CHECK) begin
        pend <= 1'b0;
      end else if (state == S_SCAN) begin
        pend <= 1'b1;
      end
      if (state == S_FIN && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // total registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_total <= BTOT_W'(BLOCK_TOTAL_RST);
      inode_total <= ITOT_W'(INODE_TOTAL_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLOCK_TOTAL: block_total <= cfg_data;
        REG_INODE_TOTAL: inode_total <= cfg_data[ITOT_W-1:0];
        default: ;
      endcase
    end
  end

  // free counters, clamped to the total when not being stepped
  always_ff @(posedge clk) begin
    if (rst) begin
      free_blocks <= FREE_B_RST;
      free_inodes <= FREE_I_RST;
    end else begin
      if (pool_r && dec) begin
        free_blocks <= free_blocks - BTOT_W'(1);
      end else if (pool_r && inc) begin
        free_blocks <= free_blocks + BTOT_W'(1);
      end else if (free_blocks > eff_block) begin
        free_blocks <= eff_block;
      end
      if (!pool_r && dec) begin
        free_inodes <= free_inodes - ITOT_W'(1);
      end else if (!pool_r && inc) begin
        free_inodes <= free_inodes + ITOT_W'(1);
      end else if (free_inodes > eff_inode) begin
        free_inodes <= eff_inode;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_r  <= cmd_word.cmd;
          pool_r <= cmd_word.pool;
          num_r  <= cmd_word.item_number;
        end
      end
      S_CHECK: begin
        rd_row   <= '0;
        row_addr <= op_row16[CW-1:0];
        if (cmd_r == CMD_ALLOC) begin
          res_status <= ST_NOSPACE;
        end else begin
          res_status <= ST_RANGE;
        end
        res_num <= '0;
        res_bit <= 1'b0;
      end
      S_SCAN: begin
        if (rd_more) begin
          rd_row <= rd_row + CW'(1);
        end
        if (ev_hit) begin
          row_addr   <= ev_row;
          wr_data    <= rd_data | (ROW_BITS'(1) << {scan.byte_sel, scan.bit_sel});
          res_status <= ST_OK;
          res_num    <= alloc_num;
          res_bit    <= 1'b1;
        end
      end
      S_OPEV: begin
        res_status <= ST_OK;
        res_num    <= num_r;
        case (cmd_r)
          CMD_FREE: res_bit <= 1'b0;
          CMD_MARK: res_bit <= 1'b1;
          default:  res_bit <= op_bit;
        endcase
      end
      S_FIN: begin
        if (rsp_free) begin
          rsp_word.status        <= res_status;
          rsp_word.result_number <= res_num;
          rsp_word.bit_value     <= res_bit;
          rsp_word.free_left     <= cur_free;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // an accepted word always goes to the check step
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> (state == S_CHECK))
    else $error("accepted command did not enter check");

  // error results carry no number and no bit
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_word.status != ST_OK)) |->
      ((rsp_word.result_number == '0) && !rsp_word.bit_value))
    else $error("error result with nonzero payload");

  // a scan hit lands inside the pool
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && ev_hit) |-> ((alloc_num != '0) && (alloc_num <= cur_total)))
    else $error("allocated number outside the pool");

  // free counts stay within the totals once a write has settled
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    ((state != S_CLEAR) && !$past(cfg_write)) |->
      ((free_blocks <= eff_block) && (free_inodes <= eff_inode)))
    else $error("free count above total");
`endif

endmodule
